/* src/shsd_pkg.sv */
// Shared types, constants and calendar helper functions for the Solar Hijri
// day-difference block. No dependencies.
package shsd_pkg;

	localparam int YEAR_BITS = 12;
	localparam int COUNT_W = 21;
	localparam int DAYNUM_W = YEAR_BITS + 10;
	localparam int RES_W = 6;

	localparam int CYCLE_YEARS = 33;
	localparam int CYCLE_LEAPS = 8;
	localparam int DAYS_PER_YEAR = 365;
	localparam int DIV33_SHIFT = 21;
	localparam int DIV33_RECIP = 63551;
	localparam int RECIP_W = 16;

	localparam logic [1:0] ORDER_EARLIER = 2'd0;
	localparam logic [1:0] ORDER_EQUAL   = 2'd1;
	localparam logic [1:0] ORDER_LATER   = 2'd2;

	typedef logic [YEAR_BITS-1:0] year_t;
	typedef logic [DAYNUM_W-1:0] daynum_t;

	typedef struct packed {
		logic [4:0]  first_day;
		logic [3:0]  first_month;
		logic [11:0] first_year;
		logic [4:0]  second_day;
		logic [3:0]  second_month;
		logic [11:0] second_year;
	} dates_t;

	typedef struct packed {
		logic [COUNT_W-1:0] day_count;
		logic [1:0]         order;
		logic               invalid;
	} result_t;

	function automatic logic leap_residue(input logic [RES_W-1:0] r);
		logic leap;
		unique case (r)
			6'd1, 6'd5, 6'd9, 6'd13, 6'd17, 6'd22, 6'd26, 6'd30: leap = 1'b1;
			default: leap = 1'b0;
		endcase
		return leap;
	endfunction

	// Number of leap years in the cycle that come before the given residue.
	function automatic logic [3:0] leaps_before(input logic [RES_W-1:0] r);
		logic [3:0] n;
		priority if (r <= 6'd1) begin
			n = 4'd0;
		end else if (r <= 6'd5) begin
			n = 4'd1;
		end else if (r <= 6'd9) begin
			n = 4'd2;
		end else if (r <= 6'd13) begin
			n = 4'd3;
		end else if (r <= 6'd17) begin
			n = 4'd4;
		end else if (r <= 6'd22) begin
			n = 4'd5;
		end else if (r <= 6'd26) begin
			n = 4'd6;
		end else if (r <= 6'd30) begin
			n = 4'd7;
		end else begin
			n = 4'd8;
		end
		return n;
	endfunction

	function automatic logic [8:0] month_offset(input logic [3:0] m);
		logic [8:0] off;
		unique case (m)
			4'd1:    off = 9'd0;
			4'd2:    off = 9'd31;
			4'd3:    off = 9'd62;
			4'd4:    off = 9'd93;
			4'd5:    off = 9'd124;
			4'd6:    off = 9'd155;
			4'd7:    off = 9'd186;
			4'd8:    off = 9'd216;
			4'd9:    off = 9'd246;
			4'd10:   off = 9'd276;
			4'd11:   off = 9'd306;
			4'd12:   off = 9'd336;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

	function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		priority if (m < 4'd7) begin
			len = 5'd31;
		end else if (m < 4'd12) begin
			len = 5'd30;
		end else begin
			len = leap ? 5'd30 : 5'd29;
		end
		return len;
	endfunction

endpackage

/* src/solar_hijri_days_between_unit.sv */
// Top level of the Solar Hijri day-difference block: input, day-number and result
// registers around shsd_day_number and shsd_compare. Depends on shsd_pkg.
//
//  channel  | signals                              | moves
//  ---------+--------------------------------------+-------------------------
//  dates    | dates_valid, dates_stall, dates      | two dates in, dates_t
//  result   | result_valid, result_stall, result   | count/order/flag, result_t
//
// One transaction is accepted every cycle while dates_stall is low; its result passes
// through the input register, day-number register and result register.
// Each stage moves on when it is empty or the stage after it moves, so bubbles close up.
// Reset clears the valid bits only; a stalled result holds until taken.
module solar_hijri_days_between_unit import shsd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    dates_valid,
	output logic    dates_stall,
	input  dates_t  dates,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic    valid_s1;
	dates_t  dates_s1;
	logic    valid_s2;
	daynum_t first_num_s2;
	daynum_t second_num_s2;
	logic    invalid_s2;
	result_t result_q;

	logic    adv1;
	logic    adv2;
	logic    adv3;
	daynum_t first_num;
	daynum_t second_num;
	logic    first_ok;
	logic    second_ok;
	result_t next_result;

	assign adv3 = !result_valid || !result_stall;
	assign adv2 = !valid_s2 || adv3;
	assign adv1 = !valid_s1 || adv2;
	assign dates_stall = !adv1;

	shsd_day_number u_first (
		.day     (dates_s1.first_day),
		.month   (dates_s1.first_month),
		.year    (YEAR_BITS'(dates_s1.first_year)),
		.day_num (first_num),
		.ok      (first_ok)
	);

	shsd_day_number u_second (
		.day     (dates_s1.second_day),
		.month   (dates_s1.second_month),
		.year    (YEAR_BITS'(dates_s1.second_year)),
		.day_num (second_num),
		.ok      (second_ok)
	);

	shsd_compare u_compare (
		.first_num  (first_num_s2),
		.second_num (second_num_s2),
		.invalid    (invalid_s2),
		.result     (next_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= dates_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				result_valid <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && dates_valid) begin
			dates_s1 <= dates;
		end
		if (adv2 && valid_s1) begin
			first_num_s2 <= first_num;
			second_num_s2 <= second_num;
			invalid_s2 <= !(first_ok && second_ok);
		end
		if (adv3 && valid_s2) begin
			result_q <= next_result;
		end
	end

	assign result = result_q;

endmodule

/* src/shsd_day_number.sv */
// Checks one Solar Hijri date and forms its closed-form day number.
// Depends on shsd_pkg.
module shsd_day_number import shsd_pkg::*; (
	input  logic [4:0] day,
	input  logic [3:0] month,
	input  year_t      year,
	output daynum_t    day_num,
	output logic       ok
);

	logic [YEAR_BITS+RECIP_W-1:0] prod;
	year_t                        quot;
	year_t                        cycle_start;
	logic [RES_W-1:0]             rem;
	logic [4:0]                   len;

	// Division by 33 through a reciprocal that is exact over the year range.
	assign prod = (YEAR_BITS+RECIP_W)'(year) * (YEAR_BITS+RECIP_W)'(DIV33_RECIP);
	assign quot = YEAR_BITS'(prod >> DIV33_SHIFT);
	assign cycle_start = YEAR_BITS'(quot * YEAR_BITS'(CYCLE_YEARS));
	assign rem = RES_W'(year - cycle_start);

	assign len = month_length(month, leap_residue(rem));
	assign ok = (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1) && (day <= len);

	assign day_num = DAYNUM_W'(year) * DAYNUM_W'(DAYS_PER_YEAR)
		+ DAYNUM_W'(quot) * DAYNUM_W'(CYCLE_LEAPS)
		+ DAYNUM_W'(leaps_before(rem))
		+ DAYNUM_W'(month_offset(month))
		+ DAYNUM_W'(day);

endmodule

/* src/shsd_compare.sv */
// Orders two day numbers and forms the inclusive day count.
// Depends on shsd_pkg.
module shsd_compare import shsd_pkg::*; (
	input  daynum_t first_num,
	input  daynum_t second_num,
	input  logic    invalid,
	output result_t result
);

	logic    first_less;
	logic    equal;
	daynum_t diff;

	assign first_less = first_num < second_num;
	assign equal = first_num == second_num;
	assign diff = first_less ? (second_num - first_num) : (first_num - second_num);

	always_comb begin
		result.invalid = invalid;
		if (invalid) begin
			result.day_count = '0;
			result.order = ORDER_EARLIER;
		end else begin
			result.day_count = COUNT_W'(diff + DAYNUM_W'(1));
			if (first_less) begin
				result.order = ORDER_EARLIER;
			end else if (equal) begin
				result.order = ORDER_EQUAL;
			end else begin
				result.order = ORDER_LATER;
			end
		end
	end

endmodule

/* src/shsd_checker.sv */
// Port-level assertions for the Solar Hijri day-difference block, bound to the top level.
// Depends on shsd_pkg and solar_hijri_days_between_unit.
module shsd_checker import shsd_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.invalid |->
			result.day_count == '0 && result.order == ORDER_EARLIER)
		else $error("Invalid transaction carries a count or an order.");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.invalid |->
			(result.order == ORDER_EQUAL) == (result.day_count == COUNT_W'(1)))
		else $error("Equal order and a count of one disagree.");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.invalid |->
			result.day_count != '0 && result.order <= ORDER_LATER)
		else $error("Valid transaction has a zero count or an unused order code.");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("Stalled result changed.");

endmodule

bind solar_hijri_days_between_unit shsd_checker u_shsd_checker (.*);
